@@ rtl/prc_pkg.sv @@
package prc_pkg;

   // widths fixed by the register map and the frame format
   localparam int THR_BITS      = 12;
   localparam int SMALL_BITS    = 8;
   localparam int VIS_BITS      = 8;
   localparam int REP_OUT_BITS  = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 12;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ARM_OPEN       = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ARM_CLOSE      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPREAD_OPEN    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPREAD_CLOSE   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONFIRM_FRAMES = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_VISIBLE    = 3'd5;

   // register reset values
   localparam logic [THR_BITS-1:0]   ARM_OPEN_RST       = 12'd256;
   localparam logic [THR_BITS-1:0]   ARM_CLOSE_RST      = 12'd0;
   localparam logic [THR_BITS-1:0]   SPREAD_OPEN_RST    = 12'd384;
   localparam logic [THR_BITS-1:0]   SPREAD_CLOSE_RST   = 12'd256;
   localparam logic [SMALL_BITS-1:0] CONFIRM_FRAMES_RST = 8'd3;
   localparam logic [SMALL_BITS-1:0] MIN_VISIBLE_RST    = 8'd128;

   // shoulder width of 10 pixels, squared
   localparam int MIN_WIDTH_SQ = 100;

   typedef struct packed {
      logic fire;
      logic valid;
      logic open;
      logic close;
   } upd_type;

   typedef struct packed {
      logic                    frame_valid;
      logic                    armed;
      logic                    phase;
      logic                    rep_done;
      logic [REP_OUT_BITS-1:0] rep_count;
   } result_type;

   // sign of d - t*sqrt(s) > 0, from signs and the squared magnitude compare
   function automatic logic cmp_gt(input logic d_pos, input logic d_zero,
                                   input logic t_neg, input logic t_zero,
                                   input logic mag_gt, input logic mag_lt);
      logic d_neg;
      logic res;
      d_neg = !d_pos && !d_zero;
      if (!d_neg && (t_neg || t_zero)) begin
         res = !(d_zero && t_zero);
      end else if (!d_pos && !t_neg) begin
         res = 1'b0;
      end else if (d_pos) begin
         res = mag_gt;
      end else begin
         res = mag_lt;
      end
      return res;
   endfunction

   // sign of d - t*sqrt(s) < 0
   function automatic logic cmp_lt(input logic d_pos, input logic d_zero,
                                   input logic t_neg, input logic t_zero,
                                   input logic mag_gt, input logic mag_lt);
      logic d_neg;
      logic res;
      d_neg = !d_pos && !d_zero;
      if (!d_neg && (t_neg || t_zero)) begin
         res = 1'b0;
      end else if (!d_pos && !t_neg) begin
         res = 1'b1;
      end else if (d_pos) begin
         res = mag_lt;
      end else begin
         res = mag_gt;
      end
      return res;
   endfunction

endpackage

@@ rtl/prc_req_if.sv @@
interface prc_req_if #(parameter int COORD_BITS = 12);
   logic                              valid;
   logic                              ready;
   logic [COORD_BITS-1:0]             left_shoulder_x;
   logic [COORD_BITS-1:0]             left_shoulder_y;
   logic [COORD_BITS-1:0]             right_shoulder_x;
   logic [COORD_BITS-1:0]             right_shoulder_y;
   logic [COORD_BITS-1:0]             left_wrist_y;
   logic [COORD_BITS-1:0]             right_wrist_y;
   logic [COORD_BITS-1:0]             left_ankle_x;
   logic [COORD_BITS-1:0]             right_ankle_x;
   logic [prc_pkg::VIS_BITS-1:0]      lowest_visibility;

   modport source (
      output valid, left_shoulder_x, left_shoulder_y, right_shoulder_x, right_shoulder_y,
             left_wrist_y, right_wrist_y, left_ankle_x, right_ankle_x, lowest_visibility,
      input  ready
   );
   modport sink (
      input  valid, left_shoulder_x, left_shoulder_y, right_shoulder_x, right_shoulder_y,
             left_wrist_y, right_wrist_y, left_ankle_x, right_ankle_x, lowest_visibility,
      output ready
   );
endinterface

@@ rtl/prc_rsp_if.sv @@
interface prc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               frame_valid;
   logic                               armed;
   logic                               phase;
   logic                               rep_done;
   logic [prc_pkg::REP_OUT_BITS-1:0]   rep_count;

   modport source (
      output valid, frame_valid, armed, phase, rep_done, rep_count,
      input  ready
   );
   modport sink (
      input  valid, frame_valid, armed, phase, rep_done, rep_count,
      output ready
   );
endinterface

@@ rtl/prc_csr_if.sv @@
interface prc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [prc_pkg::CSR_IDX_BITS-1:0]    index;
   logic [prc_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

@@ rtl/pose_rep_counter.sv @@
// an item is taken only while the sequencer is idle, so a new item waits until the last one is done
// each item takes 13 passes through the one shared multiplier plus capture, the last threshold
//   compare and the update of the posture tracker
// a result waiting at the output does not block the next item; only the final update waits
// reset: synchronous, active high; clears the sequencer, the tracker state, the count and
//   the output valid, and loads the configuration registers with their reset values
module pose_rep_counter #(
   parameter int COORD_BITS = 12,
   parameter int COUNT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   prc_req_if.sink    req_if,
   prc_rsp_if.source  rsp_if,
   prc_csr_if.sink    csr_if
);

   // datapath widths
   localparam int S_W     = 2 * COORD_BITS + 1;             // dx^2 + dy^2
   localparam int SQ_W    = 2 * COORD_BITS;                 // one squared difference
   localparam int MUL_A_W = S_W + prc_pkg::THR_BITS;        // s or t*s
   localparam int MUL_B_W = (COORD_BITS > prc_pkg::THR_BITS) ? COORD_BITS : prc_pkg::THR_BITS;
   localparam int P_W     = MUL_A_W + MUL_B_W;
   localparam int CMP_W   = S_W + 2 * prc_pkg::THR_BITS;    // t^2 * s

   // sequencer steps
   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] ST_IDLE = 4'd0;
   localparam logic [STEP_BITS-1:0] ST_DX   = 4'd1;
   localparam logic [STEP_BITS-1:0] ST_DY   = 4'd2;
   localparam logic [STEP_BITS-1:0] ST_LL   = 4'd3;
   localparam logic [STEP_BITS-1:0] ST_RL   = 4'd4;
   localparam logic [STEP_BITS-1:0] ST_SP   = 4'd5;
   localparam logic [STEP_BITS-1:0] ST_AO1  = 4'd6;
   localparam logic [STEP_BITS-1:0] ST_AO2  = 4'd7;
   localparam logic [STEP_BITS-1:0] ST_AC1  = 4'd8;
   localparam logic [STEP_BITS-1:0] ST_AC2  = 4'd9;
   localparam logic [STEP_BITS-1:0] ST_SO1  = 4'd10;
   localparam logic [STEP_BITS-1:0] ST_SO2  = 4'd11;
   localparam logic [STEP_BITS-1:0] ST_SC1  = 4'd12;
   localparam logic [STEP_BITS-1:0] ST_SC2  = 4'd13;
   localparam logic [STEP_BITS-1:0] ST_SC3  = 4'd14;
   localparam logic [STEP_BITS-1:0] ST_DONE = 4'd15;

   // configuration registers
   logic [prc_pkg::THR_BITS-1:0]   arm_open_ff, arm_close_ff;
   logic [prc_pkg::THR_BITS-1:0]   spread_open_ff, spread_close_ff;
   logic [prc_pkg::SMALL_BITS-1:0] confirm_frames_ff, min_visible_ff;

   // sequencer and captured frame
   logic [STEP_BITS-1:0]  step_ff;
   logic [COORD_BITS-1:0] dx_mag_ff, dy_mag_ff, ll_mag_ff, rl_mag_ff, sp_mag_ff;
   logic                  ll_pos_ff, ll_zero_ff, rl_pos_ff, rl_zero_ff;
   logic                  vis_ok_ff;
   logic [S_W-1:0]        s_ff;
   logic [SQ_W-1:0]       dll_ff, drl_ff, dsp_ff;
   logic                  open_ff, close_ff;

   // output register
   logic                  rsp_valid_ff;
   prc_pkg::result_type   rsp_ff;

   logic                  req_fire;
   logic                  rsp_free;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [P_W-1:0]        p_ff;

   // threshold under multiply and threshold under compare
   logic [prc_pkg::THR_BITS-1:0] thr_raw, cmp_raw;
   logic                         thr_signed, cmp_signed;
   logic [prc_pkg::THR_BITS-1:0] thr_mag;
   logic                         cmp_neg, cmp_zero;

   // magnitude compare against t^2 * s
   logic [CMP_W-1:0]      tt, dd_a, dd_b;
   logic                  a_pos, a_zero;
   logic                  a_gt, a_lt, b_gt, b_lt;
   logic                  gt_a, lt_a, gt_b, lt_b;

   prc_pkg::upd_type      upd;
   prc_pkg::result_type   res;

   function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] p,
                                                     input logic [COORD_BITS-1:0] q);
      return (p > q) ? (p - q) : (q - p);
   endfunction

   assign req_fire      = req_if.valid && req_if.ready;
   assign req_if.ready  = (step_ff == ST_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready  = 1'b1;

   // register writes; an index past the map is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_open_ff       <= prc_pkg::ARM_OPEN_RST;
         arm_close_ff      <= prc_pkg::ARM_CLOSE_RST;
         spread_open_ff    <= prc_pkg::SPREAD_OPEN_RST;
         spread_close_ff   <= prc_pkg::SPREAD_CLOSE_RST;
         confirm_frames_ff <= prc_pkg::CONFIRM_FRAMES_RST;
         min_visible_ff    <= prc_pkg::MIN_VISIBLE_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            prc_pkg::CSR_ARM_OPEN: begin
               arm_open_ff <= csr_if.data[prc_pkg::THR_BITS-1:0];
            end
            prc_pkg::CSR_ARM_CLOSE: begin
               arm_close_ff <= csr_if.data[prc_pkg::THR_BITS-1:0];
            end
            prc_pkg::CSR_SPREAD_OPEN: begin
               spread_open_ff <= csr_if.data[prc_pkg::THR_BITS-1:0];
            end
            prc_pkg::CSR_SPREAD_CLOSE: begin
               spread_close_ff <= csr_if.data[prc_pkg::THR_BITS-1:0];
            end
            prc_pkg::CSR_CONFIRM_FRAMES: begin
               confirm_frames_ff <= csr_if.data[prc_pkg::SMALL_BITS-1:0];
            end
            prc_pkg::CSR_MIN_VISIBLE: begin
               min_visible_ff <= csr_if.data[prc_pkg::SMALL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // threshold fed to the multiplier in each t*s / (t*s)*t pair
   always_comb begin
      case (step_ff)
         ST_AO1, ST_AO2: begin
            thr_raw    = arm_open_ff;
            thr_signed = 1'b1;
         end
         ST_AC1, ST_AC2: begin
            thr_raw    = arm_close_ff;
            thr_signed = 1'b1;
         end
         ST_SO1, ST_SO2: begin
            thr_raw    = spread_open_ff;
            thr_signed = 1'b0;
         end
         default: begin
            thr_raw    = spread_close_ff;
            thr_signed = 1'b0;
         end
      endcase
      thr_mag = (thr_signed && thr_raw[prc_pkg::THR_BITS-1]) ?
                (~thr_raw + prc_pkg::THR_BITS'(1)) : thr_raw;
   end

   // threshold whose t^2 * s sits in the product register this step
   always_comb begin
      case (step_ff)
         ST_AC1: begin
            cmp_raw    = arm_open_ff;
            cmp_signed = 1'b1;
         end
         ST_SO1: begin
            cmp_raw    = arm_close_ff;
            cmp_signed = 1'b1;
         end
         ST_SC1: begin
            cmp_raw    = spread_open_ff;
            cmp_signed = 1'b0;
         end
         default: begin
            cmp_raw    = spread_close_ff;
            cmp_signed = 1'b0;
         end
      endcase
      cmp_neg  = cmp_signed && cmp_raw[prc_pkg::THR_BITS-1];
      cmp_zero = (cmp_raw == '0);
   end

   // operand select for the shared multiplier
   always_comb begin
      case (step_ff)
         ST_DX: begin
            mul_a = MUL_A_W'(dx_mag_ff);
            mul_b = MUL_B_W'(dx_mag_ff);
         end
         ST_DY: begin
            mul_a = MUL_A_W'(dy_mag_ff);
            mul_b = MUL_B_W'(dy_mag_ff);
         end
         ST_LL: begin
            mul_a = MUL_A_W'(ll_mag_ff);
            mul_b = MUL_B_W'(ll_mag_ff);
         end
         ST_RL: begin
            mul_a = MUL_A_W'(rl_mag_ff);
            mul_b = MUL_B_W'(rl_mag_ff);
         end
         ST_SP: begin
            mul_a = MUL_A_W'(sp_mag_ff);
            mul_b = MUL_B_W'(sp_mag_ff);
         end
         ST_AO1, ST_AC1, ST_SO1, ST_SC1: begin
            mul_a = MUL_A_W'(s_ff);
            mul_b = MUL_B_W'(thr_mag);
         end
         ST_AO2, ST_AC2, ST_SO2, ST_SC2: begin
            mul_a = p_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(thr_mag);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   prc_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p_ff  (p_ff)
   );

   // d = 256 * diff, so d^2 is diff^2 shifted up by 16
   assign tt    = p_ff[CMP_W-1:0];
   assign dd_a  = (step_ff == ST_SC1 || step_ff == ST_SC3) ?
                  CMP_W'({dsp_ff, 16'h0000}) : CMP_W'({dll_ff, 16'h0000});
   assign dd_b  = CMP_W'({drl_ff, 16'h0000});
   assign a_pos  = (step_ff == ST_SC1 || step_ff == ST_SC3) ? (sp_mag_ff != '0) : ll_pos_ff;
   assign a_zero = (step_ff == ST_SC1 || step_ff == ST_SC3) ? (sp_mag_ff == '0) : ll_zero_ff;
   assign a_gt  = dd_a > tt;
   assign a_lt  = dd_a < tt;
   assign b_gt  = dd_b > tt;
   assign b_lt  = dd_b < tt;
   assign gt_a  = prc_pkg::cmp_gt(a_pos, a_zero, cmp_neg, cmp_zero, a_gt, a_lt);
   assign lt_a  = prc_pkg::cmp_lt(a_pos, a_zero, cmp_neg, cmp_zero, a_gt, a_lt);
   assign gt_b  = prc_pkg::cmp_gt(rl_pos_ff, rl_zero_ff, cmp_neg, cmp_zero, b_gt, b_lt);
   assign lt_b  = prc_pkg::cmp_lt(rl_pos_ff, rl_zero_ff, cmp_neg, cmp_zero, b_gt, b_lt);

   // sequencer: one multiply issued per step, its product captured the next step
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         case (step_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  step_ff <= ST_DX;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  step_ff <= ST_IDLE;
               end
            end
            default: begin
               step_ff <= step_ff + STEP_BITS'(1);
            end
         endcase
      end
   end

   // captured frame and intermediate products
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dx_mag_ff  <= absdiff(req_if.left_shoulder_x, req_if.right_shoulder_x);
         dy_mag_ff  <= absdiff(req_if.left_shoulder_y, req_if.right_shoulder_y);
         ll_mag_ff  <= absdiff(req_if.left_shoulder_y, req_if.left_wrist_y);
         rl_mag_ff  <= absdiff(req_if.right_shoulder_y, req_if.right_wrist_y);
         sp_mag_ff  <= absdiff(req_if.left_ankle_x, req_if.right_ankle_x);
         ll_pos_ff  <= req_if.left_shoulder_y > req_if.left_wrist_y;
         ll_zero_ff <= req_if.left_shoulder_y == req_if.left_wrist_y;
         rl_pos_ff  <= req_if.right_shoulder_y > req_if.right_wrist_y;
         rl_zero_ff <= req_if.right_shoulder_y == req_if.right_wrist_y;
         vis_ok_ff  <= req_if.lowest_visibility >= min_visible_ff;
      end
      case (step_ff)
         ST_DY: begin
            s_ff <= p_ff[S_W-1:0];
         end
         ST_LL: begin
            s_ff <= s_ff + p_ff[S_W-1:0];
         end
         ST_RL: begin
            dll_ff <= p_ff[SQ_W-1:0];
         end
         ST_SP: begin
            drl_ff <= p_ff[SQ_W-1:0];
         end
         ST_AO1: begin
            dsp_ff <= p_ff[SQ_W-1:0];
         end
         ST_AC1: begin
            open_ff <= gt_a && gt_b;             // both arms above open
         end
         ST_SO1: begin
            close_ff <= lt_a && lt_b;            // both arms below close
         end
         ST_SC1: begin
            open_ff <= open_ff && gt_a;          // legs spread past open
         end
         ST_SC3: begin
            close_ff <= close_ff && lt_a;        // legs together past close
         end
         default: begin
         end
      endcase
   end

   // posture tracker update at the end of each item
   always_comb begin
      upd.fire  = (step_ff == ST_DONE) && rsp_free;
      upd.valid = vis_ok_ff && (s_ff >= S_W'(prc_pkg::MIN_WIDTH_SQ));
      upd.open  = open_ff;
      upd.close = close_ff;
   end

   prc_tracker #(
      .COUNT_BITS (COUNT_BITS)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .upd            (upd),
      .confirm_frames (confirm_frames_ff),
      .res            (res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd.fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.frame_valid = rsp_ff.frame_valid;
   assign rsp_if.armed       = rsp_ff.armed;
   assign rsp_if.phase       = rsp_ff.phase;
   assign rsp_if.rep_done    = rsp_ff.rep_done;
   assign rsp_if.rep_count   = rsp_ff.rep_count;

`ifndef SYNTH
   // a repetition completes only when armed and back in the ready phase
   a_done_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.rep_done |-> rsp_if.armed && !rsp_if.phase)
      else $error("rep_done outside armed ready phase");

   // the open phase is never reported before arming
   a_phase_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.armed |-> !rsp_if.phase)
      else $error("open phase while not armed");

   // an invalid frame never completes a repetition
   a_invalid_no_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.frame_valid |-> !rsp_if.rep_done)
      else $error("rep_done on invalid frame");

   // a new result only comes out of the final sequencer step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff == ST_DONE))
      else $error("result raised outside final step");
`endif

endmodule

@@ rtl/prc_mul.sv @@
module prc_mul #(
   parameter int A_W = 37,
   parameter int B_W = 12
) (
   input  logic               clock,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p_ff
);

   // shared unsigned multiplier, product registered
   always_ff @(posedge clock) begin
      p_ff <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
   end

endmodule

@@ rtl/prc_tracker.sv @@
module prc_tracker #(
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  prc_pkg::upd_type                upd,
   input  logic [prc_pkg::SMALL_BITS-1:0]  confirm_frames,
   output prc_pkg::result_type             res
);

   logic                           armed_ff, armed_in;
   logic                           phase_ff, phase_in;
   logic [prc_pkg::SMALL_BITS-1:0] settle_ff, settle_in;
   logic [prc_pkg::SMALL_BITS-1:0] open_run_ff, open_run_in;
   logic [prc_pkg::SMALL_BITS-1:0] close_run_ff, close_run_in;
   logic [COUNT_BITS-1:0]          reps_ff, reps_in;
   logic                           done;
   logic [prc_pkg::SMALL_BITS-1:0] need;
   logic [prc_pkg::SMALL_BITS-1:0] settle_inc, open_inc, close_inc;
   logic [31:0]                    reps_wide;

   // zero frames to confirm behaves like one
   assign need       = (confirm_frames == '0) ? prc_pkg::SMALL_BITS'(1) : confirm_frames;
   assign settle_inc = settle_ff + prc_pkg::SMALL_BITS'(1);
   assign open_inc   = open_run_ff + prc_pkg::SMALL_BITS'(1);
   assign close_inc  = close_run_ff + prc_pkg::SMALL_BITS'(1);

   always_comb begin
      armed_in     = armed_ff;
      phase_in     = phase_ff;
      settle_in    = settle_ff;
      open_run_in  = open_run_ff;
      close_run_in = close_run_ff;
      reps_in      = reps_ff;
      done         = 1'b0;
      if (!upd.valid) begin
         settle_in    = '0;
         open_run_in  = '0;
         close_run_in = '0;
      end else if (!armed_ff) begin
         if (upd.close) begin
            settle_in = settle_inc;
            if (settle_inc >= need) begin
               armed_in  = 1'b1;
               settle_in = '0;
               phase_in  = 1'b0;
            end
         end else begin
            settle_in = '0;
         end
      end else if (!phase_ff) begin
         if (upd.open) begin
            open_run_in = open_inc;
            if (open_inc >= need) begin
               phase_in     = 1'b1;
               open_run_in  = '0;
               close_run_in = '0;
            end
         end else begin
            open_run_in = '0;
         end
      end else begin
         if (upd.close) begin
            close_run_in = close_inc;
            if (close_inc >= need) begin
               if (reps_ff != '1) begin
                  reps_in = reps_ff + COUNT_BITS'(1);
               end
               done         = 1'b1;
               phase_in     = 1'b0;
               close_run_in = '0;
               open_run_in  = '0;
            end
         end else begin
            close_run_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         phase_ff     <= 1'b0;
         settle_ff    <= '0;
         open_run_ff  <= '0;
         close_run_ff <= '0;
         reps_ff      <= '0;
      end else if (upd.fire) begin
         armed_ff     <= armed_in;
         phase_ff     <= phase_in;
         settle_ff    <= settle_in;
         open_run_ff  <= open_run_in;
         close_run_ff <= close_run_in;
         reps_ff      <= reps_in;
      end
   end

   assign reps_wide = 32'(reps_in);

   always_comb begin
      res.frame_valid = upd.valid;
      res.armed       = armed_in;
      res.phase       = phase_in;
      res.rep_done    = done;
      res.rep_count   = reps_wide[prc_pkg::REP_OUT_BITS-1:0];
   end

endmodule
